// ===== hdl/acl_pkg.sv =====
`timescale 1ns / 1ps
package acl_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int NCELLS_DEF      = 16;
  localparam int MAX_LAG         = 1024;
  localparam int LEN_W           = 11;
  localparam int MINB_W          = 13;
  localparam int USE_W           = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int FAR_DIFF        = 99999;
  localparam int FAR_W           = 17;
  localparam int PROD_W          = 2 * SAMPLE_BITS + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_BLOCK = 3'd0,
    REG_LEN_A     = 3'd1,
    REG_LEN_B     = 3'd2,
    REG_LEN_C     = 3'd3,
    REG_LEN_D     = 3'd4,
    REG_LEN_USE   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] im;
    logic signed [SAMPLE_BITS-1:0] re;
  } smp_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== hdl/acl_cell.sv =====
`timescale 1ns / 1ps
module acl_cell #(
  parameter int ACC_W = 46
) (
  input  logic                    clk,
  input  logic                    rst,
  input  acl_pkg::cell_ctl_t      ctl,
  input  acl_pkg::smp_t           a_in,
  input  logic                    a_vld_in,
  input  acl_pkg::smp_t           b_in,
  input  logic                    b_vld,
  input  logic signed [ACC_W-1:0] acc_re_in,
  input  logic signed [ACC_W-1:0] acc_im_in,
  output acl_pkg::smp_t           a_out,
  output logic                    a_vld_out,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im
);
  import acl_pkg::*;

  localparam int MW = 2 * SAMPLE_BITS;

  logic signed [MW-1:0]     m_ac, m_bd, m_bc, m_ad;
  logic signed [PROD_W-1:0] p_re_next, p_im_next;
  logic signed [PROD_W-1:0] p_re, p_im;
  logic                     p_vld;

  // x[i] * conj(x[i+k]) with a = x[i] and b = x[i+k].
  always_comb begin
    m_ac = $signed(a_in.re) * $signed(b_in.re);
    m_bd = $signed(a_in.im) * $signed(b_in.im);
    m_bc = $signed(a_in.im) * $signed(b_in.re);
    m_ad = $signed(a_in.re) * $signed(b_in.im);
    p_re_next = {m_ac[MW-1], m_ac} + {m_bd[MW-1], m_bd};
    p_im_next = {m_bc[MW-1], m_bc} - {m_ad[MW-1], m_ad};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld_out <= 1'b0;
      p_vld     <= 1'b0;
    end else if (ctl.clr) begin
      a_vld_out <= 1'b0;
      p_vld     <= 1'b0;
    end else begin
      a_vld_out <= a_vld_in;
      p_vld     <= a_vld_in && b_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_out <= a_in;
    p_re  <= p_re_next;
    p_im  <= p_im_next;
    if (ctl.clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (ctl.shift) begin
      acc_re <= acc_re_in;
      acc_im <= acc_im_in;
    end else if (p_vld) begin
      acc_re <= acc_re + {{(ACC_W-PROD_W){p_re[PROD_W-1]}}, p_re};
      acc_im <= acc_im + {{(ACC_W-PROD_W){p_im[PROD_W-1]}}, p_im};
    end
  end

endmodule

// ===== hdl/acl_sermul.sv =====
`timescale 1ns / 1ps
module acl_sermul #(
  parameter int A_W = 93,
  parameter int B_W = 46
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] p
);
  localparam int P_W = A_W + B_W;
  localparam int CW  = $clog2(B_W + 1);

  logic [P_W-1:0] mcand;
  logic [B_W-1:0] mplier;
  logic [CW-1:0]  cnt;
  logic           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(B_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One multiplier bit per cycle, shift and add.
  always_ff @(posedge clk) begin
    if (start) begin
      p      <= '0;
      mcand  <= P_W'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        p <= p + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

endmodule

// ===== hdl/autocorr_symbol_length_estimator_top.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake          | Contents
// s_*       | in        | s_tvalid/s_tready  | s_tdata: sample_re, sample_im; s_tlast: block_end
// m_*       | out       | m_tvalid/m_tready  | m_tdata: peak_lag, symbol_length
// cfg_*     | in        | cfg_we             | cfg_idx register index, cfg_data value
//
// Samples are taken one item per cycle while the block collects a frame.
// After the last item, lags are handled in groups of NCELLS; each group runs a clear,
// a pass over the frame and a drain in the cell row.
// Every lag then takes five products in the shared shift-add multiplier, and the
// first lag of the search three; this sets the compute time.
// Reset is synchronous; s_tready is low while a frame is computed or its result
// waits to load into the output register. A stalled result holds its data.
module autocorr_symbol_length_estimator_top #(
  parameter int MAX_SAMPLES = acl_pkg::MAX_SAMPLES_DEF,
  parameter int NCELLS      = acl_pkg::NCELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // [15:0] sample_re, [31:16] sample_im
  input  logic                            s_tlast,  // block_end
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,  // [9:0] peak_lag, [20:10] symbol_length
  input  logic                            cfg_we,
  input  logic [acl_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [acl_pkg::MINB_W-1:0]      cfg_data
);
  import acl_pkg::*;

  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = AW + 1;
  localparam int XW     = (CNT_W > MINB_W) ? CNT_W : MINB_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int MAG_W  = 2 * ACC_W + 1;
  localparam int DSQ_W  = 2 * CNT_W;
  localparam int P_W    = MAG_W + ACC_W;
  localparam int GW     = $clog2(NCELLS + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CLEAR = 12'b000000000010,
    S_PASS  = 12'b000000000100,
    S_DRAIN = 12'b000000001000,
    S_LOAD  = 12'b000000010000,
    S_M_RE  = 12'b000000100000,
    S_M_IM  = 12'b000001000000,
    S_M_DK  = 12'b000010000000,
    S_M_LHS = 12'b000100000000,
    S_M_RHS = 12'b001000000000,
    S_NEXT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [MINB_W-1:0] min_blk;
  logic [LEN_W-1:0]  typ_len [4];
  logic [USE_W-1:0]  len_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_blk    <= '0;
      typ_len[0] <= LEN_W'(64);
      typ_len[1] <= LEN_W'(128);
      typ_len[2] <= LEN_W'(256);
      typ_len[3] <= LEN_W'(512);
      len_use    <= USE_W'(4);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MIN_BLOCK: min_blk    <= cfg_data;
        REG_LEN_A:     typ_len[0] <= cfg_data[LEN_W-1:0];
        REG_LEN_B:     typ_len[1] <= cfg_data[LEN_W-1:0];
        REG_LEN_C:     typ_len[2] <= cfg_data[LEN_W-1:0];
        REG_LEN_D:     typ_len[3] <= cfg_data[LEN_W-1:0];
        REG_LEN_USE:   len_use    <= cfg_data[USE_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths in use clamp to 1..4; the last valid one bounds the lags.
  logic [USE_W-1:0] use_c;
  logic [LEN_W-1:0] m_len;
  always_comb begin
    if (len_use == '0) begin
      use_c = USE_W'(1);
    end else if (len_use > USE_W'(4)) begin
      use_c = USE_W'(4);
    end else begin
      use_c = len_use;
    end
    m_len = typ_len[use_c[1:0] - 2'd1];
    if (m_len > LEN_W'(MAX_LAG)) begin
      m_len = LEN_W'(MAX_LAG);
    end
  end

  // Sample memory and frame counter.
  logic [31:0]      mem [MAX_SAMPLES];
  logic [CNT_W-1:0] cnt;
  logic [XW-1:0]    n_now;
  logic             s_acc, wr_en;

  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign wr_en    = s_acc && (cnt < CNT_W'(MAX_SAMPLES));
  assign n_now    = wr_en ? XW'(cnt) + XW'(1) : XW'(cnt);

  logic [XW-1:0]    n_reg, t;
  logic [LEN_W-1:0] g, k, best;
  logic [XW-1:0]    tb;
  logic [31:0]      rd_a, rd_b;
  logic             issue, rd_vld;

  assign issue = (state == S_PASS);
  assign tb    = t + XW'(g);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt[AW-1:0]] <= s_tdata;
    end
    rd_a <= mem[t[AW-1:0]];
    rd_b <= mem[tb[AW-1:0]];
  end

  // Cell row: sample x[t] enters cell 0 and moves one cell per cycle, x[t+g] goes
  // to every cell, so cell c sums lag g + c. Sums then shift down to cell 0.
  cell_ctl_t              cctl;
  smp_t                   a_chain   [NCELLS+1];
  logic                   vld_chain [NCELLS+1];
  logic signed [ACC_W-1:0] acc_re_c [NCELLS+1];
  logic signed [ACC_W-1:0] acc_im_c [NCELLS+1];

  assign cctl.clr      = (state == S_CLEAR);
  assign cctl.shift    = (state == S_LOAD);
  assign a_chain[0]    = smp_t'(rd_a);
  assign vld_chain[0]  = rd_vld;
  assign acc_re_c[NCELLS] = '0;
  assign acc_im_c[NCELLS] = '0;

  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    smp_t                    a_o;
    logic                    v_o;
    logic signed [ACC_W-1:0] ar, ai;
    acl_cell #(.ACC_W(ACC_W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (cctl),
      .a_in      (a_chain[c]),
      .a_vld_in  (vld_chain[c]),
      .b_in      (smp_t'(rd_b)),
      .b_vld     (rd_vld),
      .acc_re_in (acc_re_c[c+1]),
      .acc_im_in (acc_im_c[c+1]),
      .a_out     (a_o),
      .a_vld_out (v_o),
      .acc_re    (ar),
      .acc_im    (ai)
    );
    assign a_chain[c+1]   = a_o;
    assign vld_chain[c+1] = v_o;
    assign acc_re_c[c]    = ar;
    assign acc_im_c[c]    = ai;
  end

  // Shared serial multiplier.
  logic             mul_start, mul_done, issued;
  logic [MAG_W-1:0] mul_a;
  logic [ACC_W-1:0] mul_b;
  logic [P_W-1:0]   mul_p;

  logic [ACC_W-1:0] abs_re, abs_im;
  logic [CNT_W-1:0] dk;
  logic [MAG_W-1:0] re2, mk, best_mag;
  logic [DSQ_W-1:0] dk2, db2;
  logic [P_W-1:0]   lhs;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_M_RE: begin
        mul_a = MAG_W'(abs_re);
        mul_b = abs_re;
      end
      S_M_IM: begin
        mul_a = MAG_W'(abs_im);
        mul_b = abs_im;
      end
      S_M_DK: begin
        mul_a = MAG_W'(dk);
        mul_b = ACC_W'(dk);
      end
      S_M_LHS: begin
        mul_a = mk;
        mul_b = ACC_W'(db2);
      end
      S_M_RHS: begin
        mul_a = best_mag;
        mul_b = ACC_W'(dk2);
      end
      default: ;
    endcase
  end

  assign mul_start = !issued && ((state == S_M_RE) || (state == S_M_IM) ||
                                 (state == S_M_DK) || (state == S_M_LHS) ||
                                 (state == S_M_RHS));

  acl_sermul #(.A_W(MAG_W), .B_W(ACC_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // Rounding to the nearest valid length; the earlier entry wins a tie.
  logic [LEN_W-1:0] sym_c;
  always_comb begin
    logic [FAR_W-1:0] diff_best;
    logic [LEN_W-1:0] diff;
    diff_best = FAR_W'(FAR_DIFF);
    sym_c     = '0;
    for (int i = 0; i < 4; i++) begin
      diff = (typ_len[i] > best) ? typ_len[i] - best : best - typ_len[i];
      if ((USE_W'(i) < use_c) && (FAR_W'(diff) < diff_best)) begin
        diff_best = FAR_W'(diff);
        sym_c     = typ_len[i];
      end
    end
  end

  logic [1:0]       dcnt;
  logic [GW-1:0]    grp_cnt;
  logic [LEN_W-1:0] m_reg, start_reg;
  logic             out_load;

  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      issued <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (mul_start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            if (wr_en) begin
              cnt <= cnt + 1'b1;
            end
            if (s_tlast) begin
              cnt <= '0;
              // Short frames, frames shorter than the lag range and an empty
              // search range give no result.
              if ((n_now > XW'(min_blk)) && (n_now >= XW'(m_len)) &&
                  (typ_len[0] < m_len)) begin
                state <= S_CLEAR;
              end
            end
          end
        end
        S_CLEAR: state <= S_PASS;
        S_PASS: begin
          if (t == n_reg - XW'(g) - XW'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (dcnt == 2'd2) begin
            state <= S_LOAD;
          end
        end
        S_LOAD:  state <= S_M_RE;
        S_M_RE:  if (mul_done) state <= S_M_IM;
        S_M_IM:  if (mul_done) state <= S_M_DK;
        S_M_DK: begin
          if (mul_done) begin
            state <= (k == start_reg) ? S_NEXT : S_M_LHS;
          end
        end
        S_M_LHS: if (mul_done) state <= S_M_RHS;
        S_M_RHS: if (mul_done) state <= S_NEXT;
        S_NEXT: begin
          if (k + 1'b1 == m_reg) begin
            state <= S_OUT;
          end else if (grp_cnt + 1'b1 == GW'(NCELLS)) begin
            state <= S_CLEAR;
          end else begin
            state <= S_LOAD;
          end
        end
        S_OUT: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers of the search.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n_reg     <= n_now;
        g         <= typ_len[0];
        k         <= typ_len[0];
        start_reg <= typ_len[0];
        m_reg     <= m_len;
      end
      S_CLEAR: begin
        t       <= '0;
        grp_cnt <= '0;
      end
      S_PASS: begin
        t    <= t + XW'(1);
        dcnt <= '0;
      end
      S_DRAIN: dcnt <= dcnt + 2'd1;
      S_LOAD: begin
        abs_re <= acc_re_c[0][ACC_W-1] ? ACC_W'(-acc_re_c[0]) : ACC_W'(acc_re_c[0]);
        abs_im <= acc_im_c[0][ACC_W-1] ? ACC_W'(-acc_im_c[0]) : ACC_W'(acc_im_c[0]);
        dk     <= CNT_W'(n_reg - XW'(k));
      end
      S_M_RE: if (mul_done) re2 <= mul_p[MAG_W-1:0];
      S_M_IM: if (mul_done) mk <= re2 + mul_p[MAG_W-1:0];
      S_M_DK: begin
        if (mul_done) begin
          dk2 <= mul_p[DSQ_W-1:0];
          if (k == start_reg) begin
            best     <= k;
            best_mag <= mk;
            db2      <= mul_p[DSQ_W-1:0];
          end
        end
      end
      S_M_LHS: if (mul_done) lhs <= mul_p;
      S_M_RHS: begin
        // |S(k)|^2 * (N-best)^2 against |S(best)|^2 * (N-k)^2.
        if (mul_done && (lhs > mul_p)) begin
          best     <= k;
          best_mag <= mk;
          db2      <= dk2;
        end
      end
      S_NEXT: begin
        k       <= k + 1'b1;
        grp_cnt <= grp_cnt + 1'b1;
        if (grp_cnt + 1'b1 == GW'(NCELLS)) begin
          g <= k + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {3'b000, sym_c, best[9:0]};
    end
  end

endmodule

// ===== hdl/acl_chk.sv =====
`timescale 1ns / 1ps
module acl_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A stalled result keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A result only follows the end of a frame, never a mid-frame item.
  a_mid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
    else $error("result after a mid-frame item");

  // A result is loaded only while input is held off for the computation.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while collecting samples");

  // Padding bits above the result fields stay zero.
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:21] == 3'b000))
    else $error("nonzero padding in result");

endmodule

bind autocorr_symbol_length_estimator_top acl_chk u_acl_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
